### rtl/tfb_pkg.sv
package tfb_pkg;

  typedef enum logic [2:0] {
    OP_PUT     = 3'd0,
    OP_INVERT  = 3'd1,
    OP_OUTLINE = 3'd2,
    OP_DOUBLE  = 3'd3,
    OP_SCROLL  = 3'd4,
    OP_FILL    = 3'd5,
    OP_READ    = 3'd6,
    OP_RDCLR   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_RDWAIT,
    ST_WRITE,
    ST_DONE
  } state_t;

  localparam int TILE_PIX = 16;
  localparam int TILE_LAST = 15;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  col_a;
    logic [4:0]  row_a;
    logic [5:0]  col_b;
    logic [4:0]  row_b;
    logic [8:0]  pixel_line;
    logic [15:0] pattern;
    logic [63:0] tile_rows_0_3;
    logic [63:0] tile_rows_4_7;
    logic [63:0] tile_rows_8_11;
    logic [63:0] tile_rows_12_15;
  } cmd_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [5:0]  dirty_col_min;
    logic [4:0]  dirty_row_min;
    logic [5:0]  dirty_col_max;
    logic [4:0]  dirty_row_max;
    logic        dirty_any;
    logic        bad_coords;
  } res_t;

endpackage

### rtl/tfb_if.sv
interface tfb_cmd_if
  import tfb_pkg::*;
  ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tfb_res_if
  import tfb_pkg::*;
  ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/tfb_ram.sv
module tfb_ram #(
  parameter int DEPTH = 16000,
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  // write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tile_framebuffer_blitter.sv
// Tile blitter over a monochrome framebuffer of PIXEL_LINES lines of
// WORDS_PER_LINE 16-bit words (leftmost pixel in the MSB). One command is
// taken at a time; a single read-modify-write sequencer walks the words a
// command touches through one framebuffer RAM, stepping through address,
// read, modify and write for each word. Put and invert touch 16 words,
// outlines walk every word of the tile rectangle (for the double outline one
// tile column wider on each side and one pixel line taller above and below),
// scroll and fill walk the whole rectangle, read fetches one word, read-clear
// and rejected commands skip the walk. After reset the framebuffer is cleared
// by a pass over all WORDS_PER_LINE*PIXEL_LINES words, during which no command
// is taken. The result is held in an output register until transferred.
module tile_framebuffer_blitter
  import tfb_pkg::*;
#(
  parameter int WORDS_PER_LINE = 40,
  parameter int PIXEL_LINES = 400
) (
  input  logic clk,
  input  logic rst,
  tfb_cmd_if.sink   cmd,
  tfb_res_if.source res
);

  localparam int DEPTH = WORDS_PER_LINE * PIXEL_LINES;
  localparam int AW = $clog2(DEPTH);
  localparam int TILE_ROWS = PIXEL_LINES / TILE_PIX;
  localparam int LW = $clog2(PIXEL_LINES + TILE_PIX + 1);
  localparam int CW = $clog2(WORDS_PER_LINE + 2);
  localparam logic [LW-1:0] TPL = LW'(TILE_PIX);

  state_t state, state_next;
  cmd_t   c;
  logic   bad;
  logic [LW-1:0] line, line_end;
  logic [CW-1:0] col, col_first, col_end;
  logic [AW-1:0] clr_addr;
  logic [AW+LW-1:0] lin_mul;
  logic [AW-1:0] addr;
  logic [15:0] rdata, wdata;
  logic        we;
  logic [1:0]  phase;
  logic [15:0] word_q;
  res_t out_q;
  logic out_valid;
  logic [5:0] dcmin, dcmax;
  logic [4:0] drmin, drmax;
  logic dvalid;

  // command ranges, widened
  logic [7:0] ca, cb, ra, rb;
  assign ca = 8'(c.col_a);
  assign cb = 8'(c.col_b);
  assign ra = 8'(c.row_a);
  assign rb = 8'(c.row_b);

  // tile rows at line width
  logic [LW-1:0] ra_l, rb_l;
  assign ra_l = LW'(c.row_a);
  assign rb_l = LW'(c.row_b);

  // check coordinates of the incoming command
  function automatic logic is_bad(cmd_t k);
    logic [7:0] a, b, x, y;
    a = 8'(k.col_a); b = 8'(k.col_b); x = 8'(k.row_a); y = 8'(k.row_b);
    case (op_t'(k.opcode))
      OP_PUT, OP_INVERT: is_bad = a >= 8'(WORDS_PER_LINE) || x >= 8'(TILE_ROWS);
      OP_OUTLINE: is_bad = a > b || x > y || b >= 8'(WORDS_PER_LINE) ||
                           y >= 8'(TILE_ROWS);
      OP_DOUBLE: is_bad = a > b || x > y || a < 8'd1 || x < 8'd1 ||
                          b + 8'd1 >= 8'(WORDS_PER_LINE) || y + 8'd1 >= 8'(TILE_ROWS);
      OP_SCROLL, OP_FILL: is_bad = b == 0 || y == 0 || a + b > 8'(WORDS_PER_LINE) ||
                                   x + y > 8'(TILE_ROWS);
      OP_READ: is_bad = a >= 8'(WORDS_PER_LINE) ||
                        11'(k.pixel_line) >= 11'(PIXEL_LINES);
      default: is_bad = 1'b0;
    endcase
  endfunction

  // source line of the current word (scroll reads one tile row lower)
  logic [LW-1:0] src_line;
  logic scroll_clear;
  assign scroll_clear = line >= (ra_l + rb_l - LW'(1)) * TPL;
  assign src_line = (op_t'(c.opcode) == OP_SCROLL && !scroll_clear) ?
                    line + LW'(TILE_PIX) : line;

  // address = line * WORDS_PER_LINE + col
  always_comb begin
    lin_mul = (AW + LW)'(src_line) * (AW + LW)'(WORDS_PER_LINE) + (AW + LW)'(col);
    addr = (state == ST_CLEAR) ? clr_addr : lin_mul[AW-1:0];
  end

  // write address uses the destination line
  logic [AW+LW-1:0] dst_mul;
  assign dst_mul = (AW + LW)'(line) * (AW + LW)'(WORDS_PER_LINE) + (AW + LW)'(col);

  tfb_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we),
    .waddr((state == ST_CLEAR) ? clr_addr : dst_mul[AW-1:0]),
    .wdata(wdata), .raddr(addr), .rdata(rdata));

  // modify: compute the new word for the current position
  logic [LW-1:0] top_l, bot_l, rel;
  logic [15:0] mask, newword;
  logic in_cols;
  always_comb begin
    top_l = ra_l * TPL;
    bot_l = rb_l * TPL + LW'(TILE_LAST);
    rel = line - top_l;
    in_cols = 8'(col) >= ca && 8'(col) <= cb;
    mask = '0;
    newword = word_q;
    case (op_t'(c.opcode))
      OP_PUT: begin
        case (rel[3:2])
          2'd0: newword = c.tile_rows_0_3[(3 - rel[1:0]) * 16 +: 16];
          2'd1: newword = c.tile_rows_4_7[(3 - rel[1:0]) * 16 +: 16];
          2'd2: newword = c.tile_rows_8_11[(3 - rel[1:0]) * 16 +: 16];
          default: newword = c.tile_rows_12_15[(3 - rel[1:0]) * 16 +: 16];
        endcase
      end
      OP_INVERT: newword = ~word_q;
      OP_OUTLINE, OP_DOUBLE: begin
        // horizontal edges cover only the tile columns, leaving outer corners clear
        if (in_cols && (line == top_l || line == bot_l)) mask = 16'hFFFF;
        if (in_cols && op_t'(c.opcode) == OP_DOUBLE &&
            (line == top_l - LW'(1) || line == bot_l + LW'(1))) mask = 16'hFFFF;
        if (line >= top_l && line <= bot_l) begin
          if (8'(col) == ca) mask[15] = 1'b1;
          if (8'(col) == cb) mask[0] = 1'b1;
          if (op_t'(c.opcode) == OP_DOUBLE) begin
            if (8'(col) == ca - 8'd1) mask[0] = 1'b1;
            if (8'(col) == cb + 8'd1) mask[15] = 1'b1;
          end
        end
        newword = word_q | mask;
      end
      OP_SCROLL: newword = scroll_clear ? 16'h0000 : word_q;
      OP_FILL: newword = c.pattern;
      default: newword = word_q;
    endcase
  end

  // walk extents
  logic dbl;
  assign dbl = op_t'(c.opcode) == OP_DOUBLE;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    we = 1'b0;
    wdata = newword;
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
        wdata = '0;
        if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: if (cmd.valid && !out_valid) state_next = ST_RUN;
      ST_RUN: begin
        if (bad || op_t'(c.opcode) == OP_RDCLR) state_next = ST_DONE;
        else state_next = ST_RDWAIT;
      end
      ST_RDWAIT: if (phase == 2'd1) state_next = ST_WRITE;
      ST_WRITE: begin
        if (op_t'(c.opcode) == OP_READ) state_next = ST_DONE;
        else begin
          we = 1'b1;
          if (col == col_end && line == line_end) state_next = ST_DONE;
          else state_next = ST_RDWAIT;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign cmd.ready = state == ST_IDLE && !out_valid;

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      phase <= '0;
      dvalid <= 1'b0;
      dcmin <= '0; dcmax <= '0; drmin <= '0; drmax <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (res.valid && res.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (cmd.valid && !out_valid) begin
          c <= cmd.data;
          bad <= is_bad(cmd.data);
        end
        ST_RUN: begin
          phase <= '0;
          // starting position and walk limits
          case (op_t'(c.opcode))
            OP_PUT, OP_INVERT: begin
              line <= top_l; line_end <= top_l + LW'(TILE_LAST);
              col <= CW'(ca); col_first <= CW'(ca); col_end <= CW'(ca);
            end
            OP_OUTLINE, OP_DOUBLE: begin
              line <= top_l - (dbl ? LW'(1) : LW'(0));
              line_end <= bot_l + (dbl ? LW'(1) : LW'(0));
              col <= CW'(ca) - (dbl ? CW'(1) : CW'(0));
              col_first <= CW'(ca) - (dbl ? CW'(1) : CW'(0));
              col_end <= CW'(cb) + (dbl ? CW'(1) : CW'(0));
            end
            OP_SCROLL, OP_FILL: begin
              line <= top_l;
              line_end <= (ra_l + rb_l) * TPL - LW'(1);
              col <= CW'(ca); col_first <= CW'(ca); col_end <= CW'(ca + cb - 8'd1);
            end
            default: begin
              line <= LW'(c.pixel_line); line_end <= LW'(c.pixel_line);
              col <= CW'(ca); col_first <= CW'(ca); col_end <= CW'(ca);
            end
          endcase
        end
        ST_RDWAIT: begin
          phase <= phase + 2'd1;
          if (phase == 2'd1) word_q <= rdata;
        end
        ST_WRITE: begin
          phase <= '0;
          if (col == col_end) begin
            col <= col_first;
            line <= line + LW'(1);
          end else col <= col + CW'(1);
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          out_q.read_data <= (op_t'(c.opcode) == OP_READ && !bad) ? word_q : 16'h0000;
          out_q.bad_coords <= bad;
          if (op_t'(c.opcode) == OP_RDCLR) begin
            out_q.dirty_col_min <= dcmin; out_q.dirty_col_max <= dcmax;
            out_q.dirty_row_min <= drmin; out_q.dirty_row_max <= drmax;
            out_q.dirty_any <= dvalid;
            dvalid <= 1'b0;
            dcmin <= '0; dcmax <= '0; drmin <= '0; drmax <= '0;
          end else begin : grow
            logic mk;
            logic [5:0] a0, a1;
            logic [4:0] b0, b1;
            mk = !bad && op_t'(c.opcode) != OP_FILL && op_t'(c.opcode) != OP_READ;
            case (op_t'(c.opcode))
              OP_PUT, OP_INVERT: begin
                a0 = c.col_a; a1 = c.col_a; b0 = c.row_a; b1 = c.row_a;
              end
              OP_OUTLINE: begin
                a0 = c.col_a; a1 = c.col_b; b0 = c.row_a; b1 = c.row_b;
              end
              OP_DOUBLE: begin
                a0 = c.col_a - 6'd1; a1 = c.col_b + 6'd1;
                b0 = c.row_a - 5'd1; b1 = c.row_b + 5'd1;
              end
              default: begin
                a0 = c.col_a; a1 = 6'(ca + cb - 8'd1);
                b0 = c.row_a; b1 = 5'(ra + rb - 8'd1);
              end
            endcase
            if (mk) begin
              dvalid <= 1'b1;
              dcmin <= (!dvalid || a0 < dcmin) ? a0 : dcmin;
              drmin <= (!dvalid || b0 < drmin) ? b0 : drmin;
              dcmax <= (!dvalid || a1 > dcmax) ? a1 : dcmax;
              drmax <= (!dvalid || b1 > drmax) ? b1 : drmax;
            end
            out_q.dirty_any <= dvalid | mk;
            out_q.dirty_col_min <= mk ? ((!dvalid || a0 < dcmin) ? a0 : dcmin) : dcmin;
            out_q.dirty_row_min <= mk ? ((!dvalid || b0 < drmin) ? b0 : drmin) : drmin;
            out_q.dirty_col_max <= mk ? ((!dvalid || a1 > dcmax) ? a1 : dcmax) : dcmax;
            out_q.dirty_row_max <= mk ? ((!dvalid || b1 > drmax) ? b1 : drmax) : drmax;
          end
        end
        default: ;
      endcase
    end
  end

  assign res.valid = out_valid;
  assign res.data = out_q;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |-> state == ST_IDLE) else $error("accept while busy");
  a_done_to_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> out_valid) else $error("result lost");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !we) else $error("write while idle");

endmodule
